// ===== rtl/pbsb_pkg.sv =====
package pbsb_pkg;

    // Number of quotient bits that one pass of the shared divider produces.
    localparam int Q_BITS = 32;

    // Configuration port widths and register indexes.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_N1 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_N2 = 8'd1;

    localparam logic [CFG_DATA_W-1:0] N1_RESET = 7'd6;
    localparam logic [CFG_DATA_W-1:0] N2_RESET = 7'd6;

    // Bias is given in percent.
    localparam int PCT_SCALE = 100;

endpackage

// ===== rtl/price_bias_with_smoothed_bias_unit.sv =====
// Channel   Direction  Handshake               Beat contents
// input     in         in_valid / in_stall     close_price, new_series
// output    out        out_valid / out_stall   bias, smoothed_bias, smoothed_valid, saturated
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One input beat is handled at a time. A close that still fills the price window
// gives no output beat. A close that gives a result runs the shared one-bit-per-cycle
// divider, first for the bias quotient and then for the smoothed average.
// Each division that is not needed (a bias that saturates before division, a zero
// window sum, or a bias window that is still filling) is skipped.
// rst_n sets both window registers to six and clears the counts, sums and pointers;
// the two rings are not cleared, since an entry is only read after it was written.
// A finished result waits in the output register while the next input beat is taken.
// A stalled output beat holds the last state, and with it the input, until it leaves.
module price_bias_with_smoothed_bias_unit
    import pbsb_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            close_price,
    input  logic                   new_series,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [31:0]     bias,
    output logic signed [31:0]     smoothed_bias,
    output logic                   smoothed_valid,
    output logic                   saturated,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Ring address, count and sum widths all follow from the window depth.
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = CW + 1;
    localparam int SW = 32 + CW;
    localparam int NW = SW + 7;
    localparam int BW = 32 + CW;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_UPDC = 10'b00_0000_0010,
        S_MAG  = 10'b00_0000_0100,
        S_MUL  = 10'b00_0000_1000,
        S_CHK  = 10'b00_0001_0000,
        S_DIV1 = 10'b00_0010_0000,
        S_UPDB = 10'b00_0100_0000,
        S_SST  = 10'b00_1000_0000,
        S_DIV2 = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } state_t;

    // A window register of zero acts as one, and one beyond the depth acts as the depth.
    function automatic logic [CW-1:0] eff_len(input logic [CFG_DATA_W-1:0] v);
        logic [CW-1:0] len;
        if (v == '0)
            len = CW'(1);
        else if (32'(v) > MAX_WINDOW)
            len = CW'(MAX_WINDOW);
        else
            len = CW'(v);
        return len;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [CFG_DATA_W-1:0] n1_reg;
    logic [CFG_DATA_W-1:0] n2_reg;
    logic [CW-1:0]         n1_eff;
    logic [CW-1:0]         n2_eff;

    // History of the price window and of the bias window.
    logic [SW-1:0]         csum_reg;
    logic [CW-1:0]         ccount_reg;
    logic [AW-1:0]         cptr_reg;
    logic signed [BW-1:0]  bsum_reg;
    logic [CW-1:0]         bcount_reg;
    logic [AW-1:0]         bptr_reg;

    // Ring memories with registered read data.
    logic [31:0]           close_mem [MAX_WINDOW];
    logic signed [31:0]    bias_mem  [MAX_WINDOW];
    logic [31:0]           cmem_rd_reg;
    logic signed [31:0]    bmem_rd_reg;
    logic [AW-1:0]         cmem_raddr;

    // Working registers of the item in flight.
    logic [31:0]           close_reg;
    logic [SW-1:0]         scaled_reg;
    logic [SW-1:0]         mag_reg;
    logic                  neg_reg;
    logic [NW-1:0]         num_reg;
    logic signed [31:0]    bias_val_reg;
    logic                  sat_val_reg;
    logic                  valid_val_reg;
    logic signed [31:0]    smooth_val_reg;

    logic                  out_valid_reg;
    logic signed [31:0]    out_bias_reg;
    logic signed [31:0]    out_smooth_reg;
    logic                  out_svalid_reg;
    logic                  out_sat_reg;

    logic                  in_take;
    logic                  out_take;
    logic                  out_load;
    logic [SW-1:0]         scaled_next;

    logic                  cfull;
    logic [SW-1:0]         csum_upd;
    logic [PW-1:0]         cptr_inc;
    logic [AW-1:0]         cptr_upd;

    logic                  bfull;
    logic signed [BW-1:0]  bold_ext;
    logic signed [BW-1:0]  bnew_ext;
    logic signed [BW-1:0]  bsum_upd;
    logic [CW-1:0]         bcount_upd;
    logic [PW-1:0]         bptr_inc;
    logic [AW-1:0]         bptr_upd;
    logic [BW-1:0]         babs;

    logic                  csum_zero;
    logic                  big;

    logic                  div_start;
    logic [SW-1:0]         div_r0;
    logic [Q_BITS-1:0]     div_feed;
    logic [SW-1:0]         div_den;
    logic                  div_done;
    logic [Q_BITS-1:0]     div_quot;

    assign n1_eff = eff_len(n1_reg);
    assign n2_eff = eff_len(n2_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // close * n1 against the window sum gives the deviation without a first division.
    assign scaled_next = close_price * n1_eff;

    // A new series starts reading at entry zero, since the pointer is cleared with it.
    assign cmem_raddr = new_series ? '0 : cptr_reg;

    // Price window update: the oldest close leaves once the window is full.
    assign cfull    = (ccount_reg >= n1_eff);
    assign csum_upd = csum_reg - (cfull ? SW'(cmem_rd_reg) : SW'(0)) + SW'(close_reg);
    assign cptr_inc = PW'(cptr_reg) + PW'(1);
    assign cptr_upd = (cptr_inc >= PW'(n1_eff)) ? '0 : cptr_inc[AW-1:0];

    // Bias window update, the same scheme on signed values.
    assign bfull      = (bcount_reg >= n2_eff);
    assign bold_ext   = bfull ? BW'(bmem_rd_reg) : BW'(0);
    assign bnew_ext   = BW'(bias_val_reg);
    assign bsum_upd   = bsum_reg - bold_ext + bnew_ext;
    assign bcount_upd = bfull ? bcount_reg : bcount_reg + CW'(1);
    assign bptr_inc   = PW'(bptr_reg) + PW'(1);
    assign bptr_upd   = (bptr_inc >= PW'(n2_eff)) ? '0 : bptr_inc[AW-1:0];
    assign babs       = bsum_reg[BW-1] ? BW'(-bsum_reg) : BW'(bsum_reg);

    // The quotient of |dev|*100*65536/sum reaches 2^32 exactly when |dev|*100 is at
    // least sum*65536; that case saturates without running the divider.
    assign csum_zero = (csum_reg == '0);
    assign big       = ((SW + 16)'(num_reg) >= {csum_reg, 16'h0000});

    // The divider is shared: the bias quotient first, then the smoothed average.
    always_comb
    begin
        div_start = 1'b0;
        div_r0    = SW'(num_reg[NW-1:16]);
        div_feed  = {num_reg[15:0], 16'h0000};
        div_den   = csum_reg;
        case (state_reg)
            S_CHK:
            begin
                div_start = !csum_zero && !big;
            end
            S_SST:
            begin
                div_start = valid_val_reg;
                div_r0    = SW'(babs[BW-1:32]);
                div_feed  = babs[31:0];
                div_den   = SW'(n2_eff);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    pbsb_div #(
        .RW    (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .r0    (div_r0),
        .feed  (div_feed),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = S_UPDC;
            end
            S_UPDC:
            begin
                // During warm-up the close only fills the window.
                state_next = cfull ? S_MAG : S_IDLE;
            end
            S_MAG:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = (csum_zero || big) ? S_UPDB : S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                    state_next = S_UPDB;
            end
            S_UPDB:
            begin
                state_next = S_SST;
            end
            S_SST:
            begin
                state_next = valid_val_reg ? S_DIV2 : S_FIN;
            end
            S_DIV2:
            begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, window registers and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n1_reg        <= N1_RESET;
            n2_reg        <= N2_RESET;
            csum_reg      <= '0;
            ccount_reg    <= '0;
            cptr_reg      <= '0;
            bsum_reg      <= '0;
            bcount_reg    <= '0;
            bptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Any write to a window register restarts the history.
            if (cfg_valid && cfg_ready && (cfg_index == CFG_N1 || cfg_index == CFG_N2))
            begin
                if (cfg_index == CFG_N1)
                    n1_reg <= cfg_data;
                else
                    n2_reg <= cfg_data;
                csum_reg   <= '0;
                ccount_reg <= '0;
                cptr_reg   <= '0;
                bsum_reg   <= '0;
                bcount_reg <= '0;
                bptr_reg   <= '0;
            end
            else if (in_take && new_series)
            begin
                csum_reg   <= '0;
                ccount_reg <= '0;
                cptr_reg   <= '0;
                bsum_reg   <= '0;
                bcount_reg <= '0;
                bptr_reg   <= '0;
            end
            else if (state_reg == S_UPDC)
            begin
                csum_reg <= csum_upd;
                cptr_reg <= cptr_upd;
                if (!cfull)
                    ccount_reg <= ccount_reg + CW'(1);
            end
            else if (state_reg == S_UPDB)
            begin
                bsum_reg   <= bsum_upd;
                bcount_reg <= bcount_upd;
                bptr_reg   <= bptr_upd;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Price ring: read at accept, written back in the next cycle.
    always_ff @(posedge clk)
    begin
        if (in_take)
            cmem_rd_reg <= close_mem[cmem_raddr];
        if (state_reg == S_UPDC)
            close_mem[cptr_reg] <= close_reg;
    end

    // Bias ring: the oldest bias is fetched while the bias itself is computed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MAG)
            bmem_rd_reg <= bias_mem[bptr_reg];
        if (state_reg == S_UPDB)
            bias_mem[bptr_reg] <= bias_val_reg;
    end

    // Datapath of the item in flight.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            close_reg  <= close_price;
            scaled_reg <= scaled_next;
        end

        if (state_reg == S_MAG)
        begin
            neg_reg <= (scaled_reg < csum_reg);
            mag_reg <= (scaled_reg < csum_reg) ? (csum_reg - scaled_reg)
                                               : (scaled_reg - csum_reg);
        end

        if (state_reg == S_MUL)
            num_reg <= NW'(mag_reg) * NW'(PCT_SCALE);

        if (state_reg == S_CHK)
        begin
            if (csum_zero)
            begin
                bias_val_reg <= 32'sd0;
                sat_val_reg  <= 1'b0;
            end
            else if (big)
            begin
                bias_val_reg <= neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                sat_val_reg  <= 1'b1;
            end
        end

        // Clamp to the Q15.16 range; the negative side reaches one step further.
        if (state_reg == S_DIV1 && div_done)
        begin
            if (neg_reg)
            begin
                if (div_quot > 32'h8000_0000)
                begin
                    bias_val_reg <= 32'sh8000_0000;
                    sat_val_reg  <= 1'b1;
                end
                else
                begin
                    bias_val_reg <= -$signed(div_quot);
                    sat_val_reg  <= 1'b0;
                end
            end
            else
            begin
                if (div_quot[31])
                begin
                    bias_val_reg <= 32'sh7FFF_FFFF;
                    sat_val_reg  <= 1'b1;
                end
                else
                begin
                    bias_val_reg <= $signed(div_quot);
                    sat_val_reg  <= 1'b0;
                end
            end
        end

        if (state_reg == S_UPDB)
            valid_val_reg <= (bcount_upd >= n2_eff);

        if (state_reg == S_SST && !valid_val_reg)
            smooth_val_reg <= 32'sd0;

        // The average is cut toward zero, so the magnitude quotient takes the sign back.
        if (state_reg == S_DIV2 && div_done)
            smooth_val_reg <= bsum_reg[BW-1] ? -$signed(div_quot) : $signed(div_quot);

        if (out_load)
        begin
            out_bias_reg   <= bias_val_reg;
            out_smooth_reg <= smooth_val_reg;
            out_svalid_reg <= valid_val_reg;
            out_sat_reg    <= sat_val_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bias           = out_bias_reg;
    assign smoothed_bias  = out_smooth_reg;
    assign smoothed_valid = out_svalid_reg;
    assign saturated      = out_sat_reg;

endmodule

// ===== rtl/pbsb_div.sv =====
module pbsb_div
    import pbsb_pkg::*;
#(
    parameter int RW = 39
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RW-1:0]       r0,
    input  logic [Q_BITS-1:0]   feed,
    input  logic [RW-1:0]       den,
    output logic                done,
    output logic [Q_BITS-1:0]   quot
);

    localparam int CNTW = $clog2(Q_BITS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     den_reg;
    logic [Q_BITS-1:0] feed_reg;
    logic [Q_BITS-1:0] quot_reg;

    logic [RW:0]       trial;
    logic [RW:0]       diff;
    logic              ge;
    logic [RW-1:0]     rem_next;

    // One restoring step per cycle. The partial remainder stays below den.
    assign trial    = {rem_reg, feed_reg[Q_BITS-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(Q_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= r0;
            den_reg  <= den;
            feed_reg <= feed;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            feed_reg <= {feed_reg[Q_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[Q_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== verif/price_bias_with_smoothed_bias_unit_tb.sv =====
module price_bias_with_smoothed_bias_unit_tb;
    import pbsb_pkg::*;

    // The rings in the block are MAX_WINDOW deep, so the shadow copies are too.
    localparam int RING_DEPTH = 64;

    // Indexes past the end of the register list. Writes to them must be dropped
    // and must leave the running history alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    // Cycles allowed after the last expected result before the block is idle.
    // A close that only fills the price window gives no beat, so SETTLE_CYCLES
    // is enough before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int FINAL_CYCLES  = 100;

    // One output beat as the block presents it.
    typedef struct packed {
        logic signed [31:0] bias;
        logic signed [31:0] smoothed_bias;
        logic               smoothed_valid;
        logic               saturated;
    } bias_beat_t;

    logic                  clk;
    logic                  rst_n;

    logic                  in_valid;
    logic                  in_stall;
    logic [31:0]           close_price;
    logic                  new_series;

    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    bias;
    logic signed [31:0]    smoothed_bias;
    logic                  smoothed_valid;
    logic                  saturated;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    price_bias_with_smoothed_bias_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .close_price    (close_price),
        .new_series     (new_series),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bias           (bias),
        .smoothed_bias  (smoothed_bias),
        .smoothed_valid (smoothed_valid),
        .saturated      (saturated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Shadow copy of the block state. The register values are kept as written,
    // so the clamping of out-of-range window lengths is modeled on every close.
    logic [CFG_DATA_W-1:0] n1_reg;
    logic [CFG_DATA_W-1:0] n2_reg;

    logic [31:0]           close_ring [RING_DEPTH];
    logic [63:0]           close_total;
    int unsigned           close_fill;
    int unsigned           close_slot;

    longint                bias_ring [RING_DEPTH];
    longint                bias_total;
    int unsigned           bias_fill;
    int unsigned           bias_slot;

    // Beats that the block still owes us, oldest first.
    bias_beat_t            bias_expect_q [$];

    // When this is low, neither side inserts gaps, so back-to-back traffic
    // is exercised as well.
    bit                    idle_on;

    int unsigned           closes_sent;
    int unsigned           results_checked;
    int unsigned           cfg_writes;
    int unsigned           error_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous bound on the whole run: every close producing a beat at the
    // full divider latency, with the longest input gap and output stall each.
    initial
    begin
        #6_000_000;
        $display("price_bias_with_smoothed_bias_unit test failed");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A window register of 0 behaves as 1, anything above the ring depth as
    // the full depth.
    function automatic int unsigned window_len(input logic [CFG_DATA_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > RING_DEPTH)
            return RING_DEPTH;
        return v;
    endfunction

    function automatic void clear_history();
        close_total = '0;
        close_fill  = 0;
        close_slot  = 0;
        bias_total  = 0;
        bias_fill   = 0;
        bias_slot   = 0;
    endfunction

    // Takes one accepted close into the shadow state. Returns 1 and fills beat
    // when the price window was already full, so the close produces a result.
    function automatic bit predict_bias(input logic [31:0] px, input logic ns,
                                        output bias_beat_t beat);
        int unsigned w1;
        int unsigned w2;
        bit          was_full;
        bit          neg;
        bit          clamp;
        logic [63:0] scaled;
        logic [63:0] mag;
        logic [63:0] quot;
        longint      pct;
        longint      avg;

        w1    = window_len(n1_reg);
        w2    = window_len(n2_reg);
        clamp = 1'b0;
        beat  = '0;

        if (ns)
            clear_history();

        was_full = (close_fill >= w1);
        if (was_full)
            close_total = close_total - close_ring[close_slot];
        else
            close_fill++;
        close_ring[close_slot] = px;
        close_total = close_total + px;
        close_slot  = (close_slot + 1 >= w1) ? 0 : close_slot + 1;

        if (!was_full)
            return 1'b0;

        // Compare close*n1 with the window sum instead of dividing twice,
        // then scale the magnitude by 100 percent in Q15.16 and cut toward zero.
        // Closes are never zero, so the sum is never zero here.
        scaled = 64'(px) * 64'(w1);
        neg    = (scaled < close_total);
        mag    = neg ? close_total - scaled : scaled - close_total;
        quot   = (mag * 64'd6553600) / close_total;

        if (neg)
        begin
            if (quot > 64'h8000_0000)
            begin
                clamp = 1'b1;
                pct   = -64'sh8000_0000;
            end
            else
                pct = -longint'(quot);
        end
        else
        begin
            if (quot > 64'h7FFF_FFFF)
            begin
                clamp = 1'b1;
                pct   = 64'sh7FFF_FFFF;
            end
            else
                pct = longint'(quot);
        end

        if (bias_fill >= w2)
            bias_total = bias_total - bias_ring[bias_slot];
        else
            bias_fill++;
        bias_ring[bias_slot] = pct;
        bias_total = bias_total + pct;
        bias_slot  = (bias_slot + 1 >= w2) ? 0 : bias_slot + 1;

        // Signed division truncates toward zero, as the block does.
        avg = (bias_fill >= w2) ? bias_total / longint'(w2) : 0;

        beat.bias           = pct[31:0];
        beat.smoothed_bias  = avg[31:0];
        beat.smoothed_valid = (bias_fill >= w2);
        beat.saturated      = clamp;
        return 1'b1;
    endfunction

    // Sends one close. The valid is left high after the beat is taken, so a
    // following call without a gap keeps the channel busy back to back.
    task automatic send_close(input logic [31:0] px, input logic ns);
        bias_beat_t  beat;
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        close_price <= px;
        new_series  <= ns;
        // The stall is stable at the falling edge; the beat moves at the next
        // rising edge when it is low.
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        closes_sent++;
        if (predict_bias(px, ns, beat))
            bias_expect_q = {bias_expect_q, beat};
    endtask

    // Lowers the input valid and waits until every owed beat has arrived and
    // the block has had time to finish a close that gives no beat.
    task automatic wait_idle(input int unsigned settle);
        in_valid <= 1'b0;
        while (bias_expect_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One register write. The valid stays high so that writes can follow each
    // other; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_writes++;
        case (idx)
            CFG_N1:
            begin
                n1_reg = val;
                clear_history();
            end
            CFG_N2:
            begin
                n2_reg = val;
                clear_history();
            end
            default: ;
        endcase
    endtask

    task automatic set_windows(input logic [CFG_DATA_W-1:0] n1_val,
                               input logic [CFG_DATA_W-1:0] n2_val);
        write_reg(CFG_N1, n1_val);
        write_reg(CFG_N2, n2_val);
        cfg_valid <= 1'b0;
    endtask

    // A fresh price level for a series: mostly moderate prices, where the
    // bias stays small and realistic, sometimes anywhere in the 32-bit range.
    function automatic logic [31:0] pick_level();
        if ($urandom_range(0, 99) < 70)
            return $urandom_range(100, 100000);
        return $urandom_range(1, 32'hFFFF_FFFF);
    endfunction

    // Next close around the current level, with occasional outliers.
    function automatic logic [31:0] pick_close(input logic [31:0] level);
        int unsigned roll;
        longint      step;
        longint      px;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return $urandom_range(1, 32'hFFFF_FFFF);
        if (roll < 8)
            return 32'h0000_0001;
        if (roll < 10)
            return 32'hFFFF_FFFF;
        step = longint'(level) / $urandom_range(2, 1000);
        px   = longint'(level) + longint'($urandom_range(0, 2 * step)) - step;
        if (px < 1)
            px = 1;
        if (px > 64'sh0_FFFF_FFFF)
            px = 64'sh0_FFFF_FFFF;
        return px[31:0];
    endfunction

    // A run of closes; a few of them start a new series at a new level, which
    // breaks the warm-up and the bias window in the middle.
    task automatic run_series(input int unsigned count);
        logic [31:0] level;
        logic        ns;
        int unsigned k;
        level = pick_level();
        for (k = 0; k < count; k++)
        begin
            ns = ($urandom_range(0, 99) < 3);
            if (ns)
                level = pick_level();
            send_close(pick_close(level), ns);
        end
    endtask

    // Default windows of six straight out of reset. The first six closes only
    // warm up; after that the extreme prices swing the bias between positive
    // and negative values, and a new series brings back the warm-up.
    task automatic test_default_windows();
        send_close(32'h0000_0001, 1'b0);
        send_close(32'hFFFF_FFFF, 1'b0);
        send_close(32'h8000_0000, 1'b0);
        send_close(32'h7FFF_FFFF, 1'b0);
        send_close(32'h0000_0005, 1'b0);
        send_close(32'h0000_0064, 1'b0);
        send_close(32'hFFFF_FFFF, 1'b0);
        send_close(32'h0000_0001, 1'b0);
        send_close(32'hAAAA_AAAA, 1'b0);
        send_close(32'h5555_5555, 1'b0);
        send_close(32'd1000, 1'b0);
        send_close(32'd1000, 1'b0);
        send_close(32'd1000, 1'b0);
        send_close(32'd2000, 1'b1);
        send_close(32'd2100, 1'b0);
        send_close(32'd1900, 1'b0);
    endtask

    // Out-of-range window values, writes past the register list, and a
    // one-point bias window that is valid at once.
    task automatic test_register_edges();
        wait_idle(SETTLE_CYCLES);
        // Zero acts as a one-close window, 127 as the full ring depth.
        set_windows(7'd0, 7'h7F);
        send_close(32'd5000, 1'b0);
        send_close(32'd5200, 1'b0);
        send_close(32'hFFFF_FFFF, 1'b0);

        // Dropped writes must not clear the history, so no warm-up follows.
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_UNUSED_LO, 7'h7F);
        write_reg(CFG_UNUSED_HI, 7'h00);
        cfg_valid <= 1'b0;
        send_close(32'd4800, 1'b0);
        send_close(32'h0000_0001, 1'b0);

        wait_idle(SETTLE_CYCLES);
        set_windows(7'd2, 7'd1);
        send_close(32'd300, 1'b0);
        send_close(32'd330, 1'b0);
        send_close(32'd270, 1'b1);
        send_close(32'd280, 1'b0);
    endtask

    // Random closes under a series of window settings, the extremes among
    // them. Every third setting runs with no gaps and no stalls at all.
    task automatic test_random_series();
        int unsigned phase;
        int unsigned w1;
        int unsigned w2;
        int unsigned count;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    w1    = 1;
                    w2    = 1;
                    count = 50;
                end
                1:
                begin
                    w1    = 64;
                    w2    = 64;
                    count = 150;
                end
                2:
                begin
                    w1    = 3;
                    w2    = 5;
                    count = 60;
                end
                3:
                begin
                    w1    = 0;
                    w2    = 127;
                    count = 90;
                end
                4:
                begin
                    w1    = 127;
                    w2    = 0;
                    count = 90;
                end
                default:
                begin
                    w1    = $urandom_range(1, 8);
                    w2    = $urandom_range(1, 8);
                    count = 20;
                end
            endcase
            wait_idle(SETTLE_CYCLES);
            idle_on = (phase % 3 != 2);
            set_windows(w1[CFG_DATA_W-1:0], w2[CFG_DATA_W-1:0]);
            run_series(count);
        end
        idle_on = 1'b1;
    endtask

    // Output stall: random stretches, redrawn whenever the last one runs out.
    initial
    begin : out_stall_gen
        int unsigned hold;
        int unsigned gap;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
                hold--;
            else
            begin
                gap       = pick_gap();
                out_stall <= (gap != 0);
                hold      = (gap != 0) ? gap - 1 : 0;
            end
        end
    end

    // Every beat that the block hands over is compared with the oldest owed
    // beat. Outputs are looked at on the falling edge, where they are settled;
    // the beat itself moves at the following rising edge.
    initial
    begin : bias_checker
        bias_beat_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                results_checked++;
                if (bias_expect_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected beat: bias %h smoothed %h valid %b sat %b",
                                 bias, smoothed_bias, smoothed_valid, saturated);
                end
                else
                begin
                    want = bias_expect_q.pop_front();
                    if (bias !== want.bias || smoothed_bias !== want.smoothed_bias ||
                        smoothed_valid !== want.smoothed_valid ||
                        saturated !== want.saturated)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("Mismatch on result %0d:", results_checked);
                            $display("  bias     exp %h got %h", want.bias, bias);
                            $display("  smoothed exp %h got %h",
                                     want.smoothed_bias, smoothed_bias);
                            $display("  valid    exp %b got %b",
                                     want.smoothed_valid, smoothed_valid);
                            $display("  sat      exp %b got %b",
                                     want.saturated, saturated);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        close_price     = 32'd1;
        new_series      = 1'b0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_N1;
        cfg_data        = N1_RESET;
        idle_on         = 1'b1;
        closes_sent     = 0;
        results_checked = 0;
        cfg_writes      = 0;
        error_count     = 0;
        n1_reg          = N1_RESET;
        n2_reg          = N2_RESET;
        clear_history();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_windows();
        test_register_edges();
        test_random_series();

        wait_idle(FINAL_CYCLES);

        $display("Sent %0d closes and checked %0d results across %0d register writes,",
                 closes_sent, results_checked, cfg_writes);
        $display("covering default, clamped and extreme windows with and without idling.");
        if (error_count == 0)
            $display("price_bias_with_smoothed_bias_unit test passed");
        else
            $display("price_bias_with_smoothed_bias_unit test failed");
        $finish;
    end

endmodule
